/* sv/trapezoidal_motion_profile_defines.svh */
// ----------------------------------------------------------------------------
// Trapezoidal motion profile assertion macros
// Shared assertion forms for the port-level property checker.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_MOTION_PROFILE_DEFINES_SVH
`define TRAPEZOIDAL_MOTION_PROFILE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tmp_pkg.sv */
// ----------------------------------------------------------------------------
// Trapezoidal motion profile package
// Word types, sequencer states, command and register codes.
// ----------------------------------------------------------------------------
package tmp_pkg;

    // Input word.
    typedef struct packed {
        logic [1:0]         action;
        logic signed [23:0] goal;
        logic [30:0]        speed_cap;
    } in_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0] profile_pos;
        logic signed [31:0] profile_vel;
        logic signed [31:0] profile_acc;
        logic signed [23:0] stop_point;
        logic               settled;
    } out_t;

    // Operands presented to the shared multiplier.
    typedef struct packed {
        logic signed [33:0] a;
        logic signed [32:0] b;
    } mul_req_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_SQ,
        ST_HI,
        ST_LO,
        ST_LIN,
        ST_SUM,
        ST_ACC,
        ST_MPOS,
        ST_PUPD,
        ST_VLIM,
        ST_VSUM,
        ST_VCLAMP,
        ST_STOP
    } state_t;

    // Command codes.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Register indexes.
    localparam logic [2:0] CFG_MAX_ACCEL   = 3'd0;
    localparam logic [2:0] CFG_STOP_FACTOR = 3'd1;
    localparam logic [2:0] CFG_TICK_PERIOD = 3'd2;
    localparam logic [2:0] CFG_SETTLE_BAND = 3'd3;
    localparam logic [2:0] CFG_UPPER_BOUND = 3'd4;
    localparam logic [2:0] CFG_LOWER_BOUND = 3'd5;

    // Register reset values.
    localparam logic [15:0]        TICK_PERIOD_RST = 16'd1311;
    localparam logic [15:0]        SETTLE_BAND_RST = 16'd256;
    localparam logic signed [23:0] UPPER_BOUND_RST = 24'sh7FFFFF;
    localparam logic signed [23:0] LOWER_BOUND_RST = 24'sh800000;

endpackage

/* sv/tmp_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 34 by 33 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module tmp_mul (
    input  logic               aclk,
    input  tmp_pkg::mul_req_t  req,
    output logic signed [66:0] prod
);

    logic signed [66:0] prod_reg;

    // The product of the operands is registered and available in the next cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

/* sv/trapezoidal_motion_profile.sv */
// ----------------------------------------------------------------------------
// Trapezoidal motion profile generator
// A tick that moves the profile runs the full sequence of states from acceptance
// to a valid result; a settling tick, a set, a reset or an unused command takes
// the shorter path. The block works on one word at a time and accepts the next
// word in the cycle after the result is registered. The pace is set by the one
// shared multiplier, which forms up to nine products in sequence per tick.
// Synchronous active-low reset clears the profile state and loads the
// register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module trapezoidal_motion_profile (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration write port
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wr_data,
    // Input channel
    input  logic          s_valid,
    output logic          s_ready,
    input  tmp_pkg::in_t  s_data,
    // Result channel
    output logic          m_valid,
    input  logic          m_ready,
    output tmp_pkg::out_t m_data
);

    localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (x < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Sequencer and control.
    tmp_pkg::state_t state_reg, state_next;
    logic            final_reg;
    logic            settled_reg;
    logic            m_valid_reg;
    logic            out_load;

    // Configuration registers.
    logic [30:0]        max_accel_reg;
    logic [31:0]        stop_factor_reg;
    logic [15:0]        tick_period_reg;
    logic [15:0]        settle_band_reg;
    logic signed [23:0] upper_bound_reg;
    logic signed [23:0] lower_bound_reg;

    // Profile state.
    logic signed [31:0] pos_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] acc_reg;
    logic signed [23:0] target_reg;
    logic [30:0]        speed_limit_reg;

    // Working registers.
    tmp_pkg::in_t       in_reg;
    logic signed [33:0] err_reg;
    logic [31:0]        lo_reg;
    logic [62:0]        a_reg;
    logic [47:0]        dist_reg;
    logic signed [31:0] acc_t_reg;
    logic signed [31:0] vsat_reg;
    tmp_pkg::out_t      out_reg;

    // Multiplier interface.
    tmp_pkg::mul_req_t  mul_req;
    logic signed [66:0] prod;

    // Combinational helpers.
    logic [31:0]        vel_mag;
    logic [31:0]        vsat_mag;
    logic signed [31:0] amax_s;
    logic signed [33:0] err_now;
    logic [33:0]        err_mag;
    logic               in_band;
    logic signed [49:0] err_w;
    logic signed [49:0] nerr_w;
    logic signed [49:0] dist_w;
    logic signed [45:0] pos_step;
    logic signed [47:0] pos_sum;
    logic signed [47:0] vel_sum;
    logic signed [49:0] pos_w;
    logic signed [49:0] stop_raw;
    logic signed [49:0] stop_neg;
    logic signed [49:0] stop_whole;
    logic signed [49:0] stop_hi;
    logic signed [49:0] stop_lim;
    logic signed [49:0] upper_w;
    logic signed [49:0] lower_w;
    logic               vel_pos;

    tmp_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // Magnitudes, error and settle check.
    assign vel_mag  = vel_reg[31] ? (~vel_reg + 32'd1) : vel_reg;
    assign vsat_mag = vsat_reg[31] ? (~vsat_reg + 32'd1) : vsat_reg;
    assign amax_s   = {1'b0, max_accel_reg};
    assign vel_pos  = !vel_reg[31] && (vel_reg != 32'sd0);
    assign err_now  = {{2{target_reg[23]}}, target_reg, 8'b0} - {{2{pos_reg[31]}}, pos_reg};
    assign err_mag  = err_now[33] ? (~err_now + 34'd1) : err_now;
    assign in_band  = err_mag < {18'b0, settle_band_reg};
    assign err_w    = {{16{err_reg[33]}}, err_reg};
    assign nerr_w   = 50'sd0 - err_w;
    assign dist_w   = {2'b0, dist_reg};

    // Position and velocity sums.
    assign pos_step = prod[66:21];
    assign pos_sum  = {{16{pos_reg[31]}}, pos_reg} + {{2{pos_step[45]}}, pos_step};
    assign vel_sum  = {{16{vel_reg[31]}}, vel_reg} + {{16{acc_t_reg[31]}}, acc_t_reg};

    // Stop point: offset by the distance, truncate toward zero, clip.
    assign pos_w      = {{18{pos_reg[31]}}, pos_reg};
    assign stop_raw   = vel_pos ? (pos_w + dist_w) : (pos_w - dist_w);
    assign stop_neg   = 50'sd0 - stop_raw;
    assign stop_whole = stop_raw[49] ? (50'sd0 - (stop_neg >>> 8)) : (stop_raw >>> 8);
    assign upper_w    = {{26{upper_bound_reg[23]}}, upper_bound_reg};
    assign lower_w    = {{26{lower_bound_reg[23]}}, lower_bound_reg};
    assign stop_hi    = (stop_whole > upper_w) ? upper_w : stop_whole;
    assign stop_lim   = (stop_hi < lower_w) ? lower_w : stop_hi;

    assign out_load = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tmp_pkg::ST_CMD;
                end
            end
            tmp_pkg::ST_CMD:    state_next = tmp_pkg::ST_SQ;
            tmp_pkg::ST_SQ:     state_next = tmp_pkg::ST_HI;
            tmp_pkg::ST_HI:     state_next = tmp_pkg::ST_LO;
            tmp_pkg::ST_LO:     state_next = tmp_pkg::ST_LIN;
            tmp_pkg::ST_LIN:    state_next = tmp_pkg::ST_SUM;
            tmp_pkg::ST_SUM: begin
                state_next = final_reg ? tmp_pkg::ST_STOP : tmp_pkg::ST_ACC;
            end
            tmp_pkg::ST_ACC:    state_next = tmp_pkg::ST_MPOS;
            tmp_pkg::ST_MPOS:   state_next = tmp_pkg::ST_PUPD;
            tmp_pkg::ST_PUPD:   state_next = tmp_pkg::ST_VLIM;
            tmp_pkg::ST_VLIM:   state_next = tmp_pkg::ST_VSUM;
            tmp_pkg::ST_VSUM:   state_next = tmp_pkg::ST_VCLAMP;
            tmp_pkg::ST_VCLAMP: state_next = tmp_pkg::ST_SQ;
            tmp_pkg::ST_STOP: begin
                if (out_load) begin
                    state_next = tmp_pkg::ST_IDLE;
                end
            end
            default:            state_next = tmp_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: ready and multiplier operands.
    always_comb begin
        s_ready   = 1'b0;
        mul_req.a = 34'sd0;
        mul_req.b = 33'sd0;
        unique case (state_reg)
            tmp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            tmp_pkg::ST_SQ: begin
                mul_req.a = {2'b0, vel_mag};
                mul_req.b = {1'b0, vel_mag};
            end
            tmp_pkg::ST_HI: begin
                mul_req.a = {2'b0, prod[63:32]};
                mul_req.b = {1'b0, stop_factor_reg};
            end
            tmp_pkg::ST_LO: begin
                mul_req.a = {2'b0, lo_reg};
                mul_req.b = {1'b0, stop_factor_reg};
            end
            tmp_pkg::ST_LIN: begin
                mul_req.a = {2'b0, vel_mag};
                mul_req.b = {17'b0, tick_period_reg};
            end
            tmp_pkg::ST_MPOS: begin
                mul_req.a = {vel_reg[31], vel_reg, 1'b0}
                          + {{2{acc_t_reg[31]}}, acc_t_reg};
                mul_req.b = {17'b0, tick_period_reg};
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control, configuration and profile state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= tmp_pkg::ST_IDLE;
            final_reg       <= 1'b0;
            settled_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            max_accel_reg   <= 31'd0;
            stop_factor_reg <= 32'd0;
            tick_period_reg <= tmp_pkg::TICK_PERIOD_RST;
            settle_band_reg <= tmp_pkg::SETTLE_BAND_RST;
            upper_bound_reg <= tmp_pkg::UPPER_BOUND_RST;
            lower_bound_reg <= tmp_pkg::LOWER_BOUND_RST;
            pos_reg         <= 32'sd0;
            vel_reg         <= 32'sd0;
            acc_reg         <= 32'sd0;
            target_reg      <= 24'sd0;
            speed_limit_reg <= 31'd0;
        end else begin
            state_reg <= state_next;

            // Register writes; unknown indexes are dropped.
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tmp_pkg::CFG_MAX_ACCEL:   max_accel_reg   <= cfg_wr_data[30:0];
                    tmp_pkg::CFG_STOP_FACTOR: stop_factor_reg <= cfg_wr_data;
                    tmp_pkg::CFG_TICK_PERIOD: tick_period_reg <= cfg_wr_data[15:0];
                    tmp_pkg::CFG_SETTLE_BAND: settle_band_reg <= cfg_wr_data[15:0];
                    tmp_pkg::CFG_UPPER_BOUND: upper_bound_reg <= cfg_wr_data[23:0];
                    tmp_pkg::CFG_LOWER_BOUND: lower_bound_reg <= cfg_wr_data[23:0];
                    default: ;
                endcase
            end

            // Result register handshake.
            if ((state_reg == tmp_pkg::ST_STOP) && out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                // Apply the command; only a moving tick runs the full profile step.
                tmp_pkg::ST_CMD: begin
                    final_reg   <= 1'b1;
                    settled_reg <= 1'b0;
                    unique case (in_reg.action)
                        tmp_pkg::ACT_TICK: begin
                            if (in_band) begin
                                pos_reg     <= {target_reg, 8'b0};
                                vel_reg     <= 32'sd0;
                                acc_reg     <= 32'sd0;
                                settled_reg <= 1'b1;
                            end else begin
                                final_reg <= 1'b0;
                            end
                        end
                        tmp_pkg::ACT_SET: begin
                            target_reg      <= in_reg.goal;
                            speed_limit_reg <= in_reg.speed_cap;
                        end
                        tmp_pkg::ACT_RESET: begin
                            target_reg <= 24'sd0;
                            pos_reg    <= 32'sd0;
                        end
                        tmp_pkg::ACT_NONE: ;
                        default: ;
                    endcase
                end
                // Integrate position with the chosen acceleration.
                tmp_pkg::ST_PUPD: begin
                    pos_reg <= sat32(pos_sum);
                end
                // Hold the new velocity to the speed limit where the acceleration pushes it past.
                tmp_pkg::ST_VCLAMP: begin
                    final_reg <= 1'b1;
                    if (vsat_mag > {1'b0, speed_limit_reg}) begin
                        if (!vsat_reg[31] && (vsat_reg != 32'sd0) &&
                            !acc_t_reg[31] && (acc_t_reg != 32'sd0)) begin
                            vel_reg <= {1'b0, speed_limit_reg};
                        end else if (vsat_reg[31] && acc_t_reg[31]) begin
                            vel_reg <= 32'sd0 - {1'b0, speed_limit_reg};
                        end else begin
                            vel_reg <= vsat_reg;
                        end
                        acc_reg <= 32'sd0;
                    end else begin
                        vel_reg <= vsat_reg;
                        acc_reg <= acc_t_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        unique case (state_reg)
            tmp_pkg::ST_CMD: begin
                err_reg <= err_now;
            end
            // Stopping distance from the partial products.
            tmp_pkg::ST_HI: begin
                lo_reg <= prod[31:0];
            end
            tmp_pkg::ST_LO: begin
                a_reg <= prod[62:0];
            end
            tmp_pkg::ST_LIN: begin
                a_reg <= a_reg + {31'b0, prod[63:32]};
            end
            tmp_pkg::ST_SUM: begin
                dist_reg <= {1'b0, a_reg[62:16]} + {20'b0, prod[47:20]};
            end
            // Pick the acceleration from error and stopping distance.
            tmp_pkg::ST_ACC: begin
                if (err_reg > 34'sd0) begin
                    if ((err_w <= dist_w) && !vel_reg[31]) begin
                        acc_t_reg <= 32'sd0 - amax_s;
                    end else begin
                        acc_t_reg <= acc_reg[31] ? 32'sd0 : amax_s;
                    end
                end else begin
                    if ((nerr_w <= dist_w) && (vel_reg[31] || (vel_reg == 32'sd0))) begin
                        acc_t_reg <= amax_s;
                    end else if (!acc_reg[31] && (acc_reg != 32'sd0)) begin
                        acc_t_reg <= 32'sd0;
                    end else begin
                        acc_t_reg <= 32'sd0 - amax_s;
                    end
                end
            end
            // Brake when the old speed already exceeds the limit.
            tmp_pkg::ST_VLIM: begin
                if (vel_mag > {1'b0, speed_limit_reg}) begin
                    acc_t_reg <= vel_pos ? (32'sd0 - amax_s) : amax_s;
                end
            end
            tmp_pkg::ST_VSUM: begin
                vsat_reg <= sat32(vel_sum);
            end
            // Register the result word.
            tmp_pkg::ST_STOP: begin
                if (out_load) begin
                    out_reg.profile_pos <= pos_reg;
                    out_reg.profile_vel <= vel_reg;
                    out_reg.profile_acc <= acc_reg;
                    out_reg.stop_point  <= stop_lim[23:0];
                    out_reg.settled     <= settled_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

/* sv/tmp_props.sv */
// ----------------------------------------------------------------------------
// Trapezoidal motion profile port checker
// Properties on the channel ports of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "trapezoidal_motion_profile_defines.svh"

module tmp_props (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input tmp_pkg::out_t m_data
);

    // A stalled result word holds its value.
    `TMP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // The block works on one word at a time.
    `TMP_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "ready held after a word was accepted")

    // A settled result has stopped motion.
    `TMP_ASSERT_SAME(a_settled_still, aclk, aresetn, m_valid && m_data.settled, (m_data.profile_vel == 32'sd0) && (m_data.profile_acc == 32'sd0), "settled result still moving")

    // A settled result sits on a whole tick.
    `TMP_ASSERT_SAME(a_settled_whole, aclk, aresetn, m_valid && m_data.settled, m_data.profile_pos[7:0] == 8'd0, "settled position not on a whole tick")

endmodule

bind trapezoidal_motion_profile tmp_props u_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
